/* rtl/core/ppc_pkg.sv */
// Shared sizes, codes and word types of the point projection colouriser.
// No dependencies; every core file refers to it by scoped names.
`default_nettype none

package ppc_pkg;

  localparam int MAX_COLS    = 1024;
  localparam int MAX_ROWS    = 512;
  localparam int FRAC_BITS   = 16;

  localparam int NUM_COEFS   = 12;
  localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int MEM_AW      = $clog2(STORE_DEPTH);

  // quotient bits: enough for the larger image dimension
  localparam int MAX_DIM     = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int QB          = $clog2(MAX_DIM);

  localparam int PW          = 64 - FRAC_BITS;   // product after the fraction shift
  localparam int SUM_W       = PW + 1;           // signed u, v, w
  localparam int MAG_W       = PW;               // magnitude of u, v, w
  localparam int DW          = MAG_W + QB;       // shifted divisor

  localparam int COLS_W      = 11;
  localparam int ROWS_W      = 10;
  localparam int DIM_W       = (QB + 1 > COLS_W) ? QB + 1 : COLS_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;

  localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(1024);
  localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(512);

  localparam logic [1:0] FUNC_POINT = 2'd0;
  localparam logic [1:0] FUNC_COEF  = 2'd1;
  localparam logic [1:0] FUNC_PIXEL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = CFG_IDX_W'(1);

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic [18:0]        pixel_address;
    logic [23:0]        pixel_rgb;
  } ppc_in_word_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [23:0]        out_rgb;
  } ppc_out_word_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] u;
    logic signed [SUM_W-1:0] v;
    logic signed [SUM_W-1:0] w;
  } ppc_uvw_t;

  typedef struct packed {
    logic             ok;
    logic             neg_u;
    logic             neg_v;
    logic [MAG_W-1:0] d;
    logic [MAG_W-1:0] ru;
    logic [MAG_W-1:0] rv;
    logic [QB-1:0]    qu;
    logic [QB-1:0]    qv;
  } ppc_div_st_t;

  typedef struct packed {
    logic          ok;
    logic          neg_u;
    logic          neg_v;
    logic [QB-1:0] qu;
    logic [QB-1:0] qv;
  } ppc_quo_t;

endpackage

`default_nettype wire

/* rtl/core/ppc_mac.sv */
// Matrix store and the multiply / sum stages giving u, v and w.
// Depends on ppc_pkg.
`default_nettype none

module ppc_mac (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire logic                 in_accept,
  input  wire ppc_pkg::ppc_in_word_t in_word,
  output logic                      s3_valid,
  output ppc_pkg::ppc_in_word_t     s3_word,
  output ppc_pkg::ppc_uvw_t         s3_uvw
);

  logic signed [31:0]           coef_r [ppc_pkg::NUM_COEFS];
  logic                         s1_valid_r, s2_valid_r, s3_valid_r;
  ppc_pkg::ppc_in_word_t        s1_word_r, s2_word_r, s3_word_r;
  logic signed [31:0]           coord [3];
  logic signed [ppc_pkg::PW-1:0] prod_r [9];
  logic signed [31:0]           c3_r [3];
  logic signed [ppc_pkg::SUM_W-1:0] sum_nxt [3];
  ppc_pkg::ppc_uvw_t            uvw_r;

  // coefficient writes land at accept; points ahead have already been sampled
  always_ff @(posedge clk) begin
    if (in_accept && in_word.func == ppc_pkg::FUNC_COEF &&
        in_word.coef_index < 4'(ppc_pkg::NUM_COEFS)) begin
      coef_r[in_word.coef_index] <= in_word.coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_accept;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_word_r <= in_word;
      s2_word_r <= s1_word_r;
      s3_word_r <= s2_word_r;
    end
  end

  assign coord[0] = s1_word_r.point_x;
  assign coord[1] = s1_word_r.point_y;
  assign coord[2] = s1_word_r.point_z;

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      logic signed [63:0] full;
      assign full = $signed(coef_r[r*4+c]) * $signed(coord[c]);
      // dropping the fraction bits is a floor shift
      always_ff @(posedge clk) begin
        if (adv) begin
          prod_r[r*3+c] <= full[63:ppc_pkg::FRAC_BITS];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        c3_r[r] <= coef_r[r*4+3];
      end
    end
    assign sum_nxt[r] = ppc_pkg::SUM_W'(prod_r[r*3])   + ppc_pkg::SUM_W'(prod_r[r*3+1]) +
                        ppc_pkg::SUM_W'(prod_r[r*3+2]) + ppc_pkg::SUM_W'(c3_r[r]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      uvw_r.u <= sum_nxt[0];
      uvw_r.v <= sum_nxt[1];
      uvw_r.w <= sum_nxt[2];
    end
  end

  assign s3_valid = s3_valid_r;
  assign s3_word  = s3_word_r;
  assign s3_uvw   = uvw_r;

endmodule

`default_nettype wire

/* rtl/core/ppc_div.sv */
// Pipelined restoring divider: col = |u|/|w| and row = |v|/|w|, one bit a stage.
// Depends on ppc_pkg.
`default_nettype none

module ppc_div (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire logic                  in_valid,
  input  wire ppc_pkg::ppc_in_word_t in_word,
  input  wire ppc_pkg::ppc_uvw_t     in_uvw,
  output logic                       q_valid,
  output ppc_pkg::ppc_in_word_t      q_word,
  output ppc_pkg::ppc_quo_t          q_quo
);

  localparam int QB = ppc_pkg::QB;

  logic                  vld_r  [QB+1];
  ppc_pkg::ppc_in_word_t word_r [QB+1];
  ppc_pkg::ppc_div_st_t  st_r   [QB+1];

  logic [ppc_pkg::MAG_W-1:0] au, av, aw;
  logic                      fit_u, fit_v;
  ppc_pkg::ppc_div_st_t      st0_nxt;

  assign au = in_uvw.u[ppc_pkg::SUM_W-1] ? ppc_pkg::MAG_W'(-in_uvw.u) : ppc_pkg::MAG_W'(in_uvw.u);
  assign av = in_uvw.v[ppc_pkg::SUM_W-1] ? ppc_pkg::MAG_W'(-in_uvw.v) : ppc_pkg::MAG_W'(in_uvw.v);
  assign aw = in_uvw.w[ppc_pkg::SUM_W-1] ? ppc_pkg::MAG_W'(-in_uvw.w) : ppc_pkg::MAG_W'(in_uvw.w);

  // quotient must fit in QB bits, else it is outside any image anyway
  assign fit_u = ppc_pkg::DW'(au) < (ppc_pkg::DW'(aw) << QB);
  assign fit_v = ppc_pkg::DW'(av) < (ppc_pkg::DW'(aw) << QB);

  always_comb begin
    st0_nxt       = '0;
    st0_nxt.ok    = (in_uvw.w != '0) && fit_u && fit_v;
    st0_nxt.neg_u = in_uvw.u[ppc_pkg::SUM_W-1] ^ in_uvw.w[ppc_pkg::SUM_W-1];
    st0_nxt.neg_v = in_uvw.v[ppc_pkg::SUM_W-1] ^ in_uvw.w[ppc_pkg::SUM_W-1];
    st0_nxt.d     = aw;
    st0_nxt.ru    = au;
    st0_nxt.rv    = av;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word_r[0] <= in_word;
      st_r[0]   <= st0_nxt;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_bit
    localparam int B = QB - k;
    logic [ppc_pkg::DW-1:0] dsh;
    logic                   ge_u, ge_v;
    ppc_pkg::ppc_div_st_t   st_nxt;

    assign dsh  = ppc_pkg::DW'(st_r[k-1].d) << B;
    assign ge_u = ppc_pkg::DW'(st_r[k-1].ru) >= dsh;
    assign ge_v = ppc_pkg::DW'(st_r[k-1].rv) >= dsh;

    always_comb begin
      st_nxt = st_r[k-1];
      if (ge_u) begin
        st_nxt.ru = ppc_pkg::MAG_W'(ppc_pkg::DW'(st_r[k-1].ru) - dsh);
      end
      if (ge_v) begin
        st_nxt.rv = ppc_pkg::MAG_W'(ppc_pkg::DW'(st_r[k-1].rv) - dsh);
      end
      st_nxt.qu[B] = ge_u;
      st_nxt.qv[B] = ge_v;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        word_r[k] <= word_r[k-1];
        st_r[k]   <= st_nxt;
      end
    end
  end

  assign q_valid     = vld_r[QB];
  assign q_word      = word_r[QB];
  assign q_quo.ok    = st_r[QB].ok;
  assign q_quo.neg_u = st_r[QB].neg_u;
  assign q_quo.neg_v = st_r[QB].neg_v;
  assign q_quo.qu    = st_r[QB].qu;
  assign q_quo.qv    = st_r[QB].qv;

endmodule

`default_nettype wire

/* rtl/core/ppc_sample.sv */
// Bounds test, image store (pixel writes and reads in stream order), output word register.
// Depends on ppc_pkg.
`default_nettype none

module ppc_sample (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         adv,
  input  wire logic                         q_valid,
  input  wire ppc_pkg::ppc_in_word_t        q_word,
  input  wire ppc_pkg::ppc_quo_t            q_quo,
  input  wire logic [ppc_pkg::COLS_W-1:0]   image_cols,
  input  wire logic [ppc_pkg::ROWS_W-1:0]   image_rows,
  output logic                              out_valid,
  output ppc_pkg::ppc_out_word_t            out_word
);

  localparam int DIM_W = ppc_pkg::DIM_W;
  localparam int AW    = ppc_pkg::MEM_AW;

  logic [DIM_W-1:0]      cols_eff, rows_eff;
  logic                  hit_nxt;
  logic [AW-1:0]         ra_nxt;
  logic                  sel_valid_r, sel_hit_r;
  ppc_pkg::ppc_in_word_t sel_word_r;
  logic [AW-1:0]         sel_ra_r;
  logic                  wr_en;
  logic [23:0]           image_mem_r [ppc_pkg::STORE_DEPTH];
  logic [23:0]           rd_rgb_r;
  logic                  out_valid_r;
  logic signed [31:0]    x_r, y_r, z_r;

  assign cols_eff = (DIM_W'(image_cols) > DIM_W'(ppc_pkg::MAX_COLS)) ?
                    DIM_W'(ppc_pkg::MAX_COLS) : DIM_W'(image_cols);
  assign rows_eff = (DIM_W'(image_rows) > DIM_W'(ppc_pkg::MAX_ROWS)) ?
                    DIM_W'(ppc_pkg::MAX_ROWS) : DIM_W'(image_rows);

  // a negative quotient truncated to zero still lands on column/row zero
  assign hit_nxt = q_word.func == ppc_pkg::FUNC_POINT && q_quo.ok &&
                   (!q_quo.neg_u || q_quo.qu == '0) &&
                   (!q_quo.neg_v || q_quo.qv == '0) &&
                   DIM_W'(q_quo.qu) < cols_eff && DIM_W'(q_quo.qv) < rows_eff;
  assign ra_nxt  = AW'(q_quo.qv) * AW'(ppc_pkg::MAX_COLS) + AW'(q_quo.qu);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      sel_valid_r <= q_valid;
      out_valid_r <= sel_valid_r && sel_hit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sel_word_r <= q_word;
      sel_hit_r  <= hit_nxt;
      sel_ra_r   <= ra_nxt;
      x_r        <= sel_word_r.point_x;
      y_r        <= sel_word_r.point_y;
      z_r        <= sel_word_r.point_z;
    end
  end

  assign wr_en = sel_word_r.func == ppc_pkg::FUNC_PIXEL &&
                 32'(sel_word_r.pixel_address) < ppc_pkg::STORE_DEPTH;

  always_ff @(posedge clk) begin
    if (adv && sel_valid_r) begin
      if (wr_en) begin
        image_mem_r[AW'(sel_word_r.pixel_address)] <= sel_word_r.pixel_rgb;
      end else if (sel_hit_r) begin
        rd_rgb_r <= image_mem_r[sel_ra_r];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_word.out_x   = x_r;
  assign out_word.out_y   = y_r;
  assign out_word.out_z   = z_r;
  assign out_word.out_rgb = rd_rgb_r;

endmodule

`default_nettype wire

/* rtl/core/point_projection_colorizer.sv */
// Top level of the point projection colouriser: config registers, stall control.
// Depends on ppc_pkg, ppc_mac, ppc_div and ppc_sample.
`default_nettype none

// One word per clock is taken in unless stalled and, once the pipeline is
// full, at most one leaves per clock. A word carries one of three functions:
// a coefficient write (takes effect for every point accepted after it), a
// pixel write (stored in stream order, so points accepted earlier still
// see the old colour) and a point projection. A point passes 3 multiply/sum
// stages, 1 + QB divider stages (one quotient bit each, QB = 10 here) and 2
// stages for bounds test and image read. Points that fall off the image or
// have w of zero leave no output word. The whole pipeline moves as one: it
// halts only while a finished word sits in the output register and the
// receiver stalls it. Configuration writes are always taken (cfg_ready
// stays high) and should only be made while the pipeline is empty.
module point_projection_colorizer (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire ppc_pkg::ppc_in_word_t           in_word,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output ppc_pkg::ppc_out_word_t               out_word,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ppc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ppc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                           adv;
  logic                           in_accept;
  logic [ppc_pkg::COLS_W-1:0]     image_cols_r;
  logic [ppc_pkg::ROWS_W-1:0]     image_rows_r;

  logic                           s3_valid;
  ppc_pkg::ppc_in_word_t          s3_word;
  ppc_pkg::ppc_uvw_t              s3_uvw;
  logic                           q_valid;
  ppc_pkg::ppc_in_word_t          q_word;
  ppc_pkg::ppc_quo_t              q_quo;

  // every stage steps together unless the output word is held
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign in_accept = in_valid && adv;
  assign cfg_ready = 1'b1;

  // config registers; writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_cols_r <= ppc_pkg::COLS_RESET;
      image_rows_r <= ppc_pkg::ROWS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ppc_pkg::CFG_IMAGE_COLS: image_cols_r <= cfg_data[ppc_pkg::COLS_W-1:0];
        ppc_pkg::CFG_IMAGE_ROWS: image_rows_r <= cfg_data[ppc_pkg::ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // u, v, w = M * (x, y, z, 1)
  ppc_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_accept (in_accept),
    .in_word   (in_word),
    .s3_valid  (s3_valid),
    .s3_word   (s3_word),
    .s3_uvw    (s3_uvw)
  );

  // truncated column and row
  ppc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (s3_valid),
    .in_word  (s3_word),
    .in_uvw   (s3_uvw),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_quo    (q_quo)
  );

  // bounds test, image store, output register
  ppc_sample u_sample (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .q_valid    (q_valid),
    .q_word     (q_word),
    .q_quo      (q_quo),
    .image_cols (image_cols_r),
    .image_rows (image_rows_r),
    .out_valid  (out_valid),
    .out_word   (out_word)
  );

endmodule

`default_nettype wire

/* rtl/core/ppc_checker.sv */
// Port-level checks on the point projection colouriser, bound to the top level.
// Depends on ppc_pkg and point_projection_colorizer.
`default_nettype none

module ppc_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire ppc_pkg::ppc_in_word_t          in_word,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire ppc_pkg::ppc_out_word_t         out_word,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready,
  input wire logic [ppc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [ppc_pkg::CFG_DATA_W-1:0] cfg_data
);

  // input only held back by a stalled output word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held output word");

  // no output word straight out of reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("stalled output word changed");

  // a stalled input word stays on offer unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_word)))
    else $error("stalled input word changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> (cfg_ready && !$isunknown({cfg_index, cfg_data})))
    else $error("config write refused or unknown");

endmodule

bind point_projection_colorizer ppc_checker u_ppc_checker (.*);

`default_nettype wire
